### hdl/afub_pkg.sv
// Shared types and constants for the stereo audio FIFO with underrun buffering.
// No dependencies; afub_core, afub_outq and the top level use it by scoped names.
package afub_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LEN_W       = 13;
  localparam int THR_W       = 14;
  localparam int SE_W        = 46;
  localparam int FILL_W      = 14;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int ENERGY_W    = 58;
  localparam int LIM_W       = SE_W + LEN_W;
  localparam int WORD_W      = 2 * SAMPLE_BITS + SQ_W;
  localparam int DEPTH_DEF   = 16384;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE   = 2'd2;

  localparam logic             ENABLED_RST   = 1'b0;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 14'd2048;
  localparam logic [SE_W-1:0]  SILENCE_RST   = 46'd7037;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                          command;
    logic                          first_of_block;
    logic                          last_of_block;
    logic [LEN_W-1:0]              block_length;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          from_store;
    logic                          push_accepted;
    logic                          buffering_now;
    logic [FILL_W-1:0]             fill_level;
  } out_beat_t;

  // registered input beat plus its precomputed square
  typedef struct packed {
    in_beat_t         beat;
    logic [SQ_W-1:0]  sq;   // in_left squared
  } work_t;

  typedef struct packed {
    logic             enabled;
    logic [THR_W-1:0] buffer_threshold;
    logic [SE_W-1:0]  silence_energy;
  } cfg_t;

endpackage

### hdl/afub_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old data. No dependencies.
module afub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/afub_core.sv
// Ring buffer control: indices, block bookkeeping, prebuffering flag, energy sum.
// Depends on afub_pkg; drives the frame RAM (afub_ram) instanced at the top level.
module afub_core #(
  parameter int DEPTH = afub_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  afub_pkg::work_t              item,
  input  afub_pkg::cfg_t               cfg,
  input  logic [afub_pkg::WORD_W-1:0]  ram_q,
  output logic                         ram_we,
  output logic [$clog2(DEPTH)-1:0]     ram_waddr,
  output logic [afub_pkg::WORD_W-1:0]  ram_wdata,
  output logic [$clog2(DEPTH)-1:0]     ram_raddr,
  output afub_pkg::out_beat_t          res
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = (AW > afub_pkg::THR_W ? AW : afub_pkg::THR_W) + 1;
  localparam int SB  = afub_pkg::SAMPLE_BITS;
  localparam int SQW = afub_pkg::SQ_W;
  localparam int EW  = afub_pkg::ENERGY_W;
  localparam int LW  = afub_pkg::LEN_W;

  logic [AW-1:0] wr_idx_r, wr_idx_nxt, rd_idx_r, rd_idx_nxt;
  logic          pre_r, pre_nxt;
  logic          push_live_r, push_live_nxt, push_ok_r, push_ok_nxt;
  logic [LW-1:0] push_left_r, push_left_nxt;
  logic          pull_live_r, pull_live_nxt, pull_gated_r, pull_gated_nxt;
  logic [LW-1:0] pull_left_r, pull_left_nxt, pull_len_r, pull_len_nxt;
  logic [EW-1:0] esum_r, esum_nxt;
  logic          byp_r, byp_nxt;
  logic [afub_pkg::WORD_W-1:0] byp_data_r;

  logic [AW:0]   diff;
  logic [AW-1:0] fill, free_sp, fill_after;
  logic [afub_pkg::WORD_W-1:0] frame;
  logic          wr, rd, live, ok, gated, first, last;
  logic [LW-1:0] len, left, plen;
  logic [afub_pkg::LIM_W-1:0] lim;
  logic [EW-1:0] esum;
  logic [EW:0]   esum_add;

  always_comb begin
    first = item.beat.first_of_block;
    last  = item.beat.last_of_block;
    len   = item.beat.block_length;

    diff    = {1'b0, wr_idx_r} - {1'b0, rd_idx_r};
    fill    = diff[AW] ? AW'(diff + (AW + 1)'(DEPTH)) : diff[AW-1:0];
    free_sp = AW'(DEPTH - 1) - fill;
    frame   = byp_r ? byp_data_r : ram_q;

    wr_idx_nxt     = wr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    pre_nxt        = pre_r;
    push_live_nxt  = push_live_r;
    push_ok_nxt    = push_ok_r;
    push_left_nxt  = push_left_r;
    pull_live_nxt  = pull_live_r;
    pull_gated_nxt = pull_gated_r;
    pull_left_nxt  = pull_left_r;
    pull_len_nxt   = pull_len_r;
    esum_nxt       = esum_r;

    wr       = 1'b0;
    rd       = 1'b0;
    live     = 1'b0;
    ok       = 1'b0;
    gated    = 1'b0;
    left     = '0;
    plen     = '0;
    lim      = '0;
    esum     = '0;
    esum_add = '0;
    fill_after = fill;

    if (fire) begin
      unique case (item.beat.command)
        afub_pkg::CMD_PUSH: begin
          live = first ? cfg.enabled : push_live_r;
          ok   = first ? (cfg.enabled && len != '0 && CW'(len) <= CW'(free_sp)) : push_ok_r;
          left = first ? (ok ? len : '0) : push_left_r;
          wr   = ok && left != '0;
          if (wr) begin
            left = left - LW'(1);
          end
          fill_after    = fill + AW'(wr);
          push_live_nxt = live;
          push_ok_nxt   = ok;
          push_left_nxt = left;
          if (last) begin
            if (live && pre_r && CW'(fill_after) >= CW'(cfg.buffer_threshold)) begin
              pre_nxt = 1'b0;
            end
            push_live_nxt = 1'b0;
            push_ok_nxt   = 1'b0;
            push_left_nxt = '0;
          end
        end
        afub_pkg::CMD_PULL: begin
          live  = first ? cfg.enabled : pull_live_r;
          gated = first ? (!cfg.enabled || pre_r) : pull_gated_r;
          plen  = first ? len : pull_len_r;
          // silence limit uses the level set when the block ends
          lim   = afub_pkg::LIM_W'(cfg.silence_energy) * afub_pkg::LIM_W'(plen);
          esum  = first ? '0 : esum_r;
          if (first) begin
            left = gated ? '0 : (CW'(fill) < CW'(len) ? LW'(fill) : len);
          end else begin
            left = pull_left_r;
          end
          rd = live && !gated && left != '0;
          if (rd) begin
            left     = left - LW'(1);
            esum_add = {1'b0, esum} + (EW + 1)'(frame[SQW-1:0]);
            esum     = esum_add[EW] ? '1 : esum_add[EW-1:0];  // saturate
          end
          fill_after     = fill - AW'(rd);
          pull_live_nxt  = live;
          pull_gated_nxt = gated;
          pull_left_nxt  = left;
          pull_len_nxt   = plen;
          esum_nxt       = esum;
          if (last) begin
            // quiet block and not enough left for another: refill first
            if (live && !gated && {1'b0, esum} < lim && CW'(fill_after) < CW'(plen)) begin
              pre_nxt = 1'b1;
            end
            pull_live_nxt  = 1'b0;
            pull_gated_nxt = 1'b0;
            pull_left_nxt  = '0;
          end
        end
        default: begin
        end
      endcase
      if (wr) begin
        wr_idx_nxt = (wr_idx_r == AW'(DEPTH - 1)) ? '0 : wr_idx_r + AW'(1);
      end
      if (rd) begin
        rd_idx_nxt = (rd_idx_r == AW'(DEPTH - 1)) ? '0 : rd_idx_r + AW'(1);
      end
    end

    res.out_left      = rd ? frame[afub_pkg::WORD_W-1 -: SB] : '0;
    res.out_right     = rd ? frame[SQW+SB-1 -: SB] : '0;
    res.from_store    = rd;
    res.push_accepted = wr;
    res.buffering_now = pre_nxt;
    res.fill_level    = afub_pkg::FILL_W'(CW'(fill_after));
  end

  assign ram_we    = wr;
  assign ram_waddr = wr_idx_r;
  assign ram_wdata = {item.beat.in_left, item.beat.in_right, item.sq};
  assign ram_raddr = rd_idx_nxt;
  // RAM returns old data on a same-address write; capture the new word instead
  assign byp_nxt   = wr && (wr_idx_r == rd_idx_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r     <= '0;
      rd_idx_r     <= '0;
      pre_r        <= 1'b1;
      push_live_r  <= 1'b0;
      push_ok_r    <= 1'b0;
      push_left_r  <= '0;
      pull_live_r  <= 1'b0;
      pull_gated_r <= 1'b0;
      pull_left_r  <= '0;
      pull_len_r   <= '0;
      esum_r       <= '0;
      byp_r        <= 1'b0;
    end else begin
      wr_idx_r     <= wr_idx_nxt;
      rd_idx_r     <= rd_idx_nxt;
      pre_r        <= pre_nxt;
      push_live_r  <= push_live_nxt;
      push_ok_r    <= push_ok_nxt;
      push_left_r  <= push_left_nxt;
      pull_live_r  <= pull_live_nxt;
      pull_gated_r <= pull_gated_nxt;
      pull_left_r  <= pull_left_nxt;
      pull_len_r   <= pull_len_nxt;
      esum_r       <= esum_nxt;
      byp_r        <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= ram_wdata;
  end

endmodule

### hdl/afub_outq.sv
// Two-entry result queue: output register plus skid register.
// Depends on afub_pkg for the result beat type.
module afub_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  afub_pkg::out_beat_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output afub_pkg::out_beat_t out_data
);

  logic                out_valid_r, skid_valid_r;
  afub_pkg::out_beat_t out_data_r, skid_data_r;
  logic                pop;

  assign pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        if (pop) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid_r || pop) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end else begin
        // hold
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end else begin
      // hold
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/audio_fifo_with_underrun_buffering.sv
// Top level of the stereo audio FIFO with underrun buffering.
// Depends on afub_pkg, afub_ram, afub_core and afub_outq.
//
// Usage:
//  - in_ channel: one beat per stereo frame. command selects push (frame from
//    the decoder) or pull (frame for the output); first/last mark block bounds,
//    block_length is read on the first beat of a block.
//  - out_ channel: exactly one result beat per input beat, in order. Pulls carry
//    the samples (zeros when not from the store); pushes report push_accepted.
//  - cfg_ port: plain write (cfg_we, cfg_index, cfg_data); write only while idle.
//  - A beat passes through the input register, then the buffer update into
//    the result queue, whose output register drives out_valid. The channel
//    takes one beat per cycle while the receiver does not stall, set by
//    the single frame RAM write or read done per beat.
//  - in_stall rises when the input register holds a beat and both result
//    registers hold beats the receiver has not taken; a stalled receiver lets
//    three more beats in before the input backs up.
//  - Reset: indices zero, store empty, prebuffering set, registers at their
//    defaults. The frame store is not cleared; no entry is read before written.
module audio_fifo_with_underrun_buffering #(
  parameter int DEPTH = afub_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  afub_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output afub_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [afub_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afub_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int SB = afub_pkg::SAMPLE_BITS;

  // configuration registers
  afub_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled          <= afub_pkg::ENABLED_RST;
      cfg_r.buffer_threshold <= afub_pkg::THRESHOLD_RST;
      cfg_r.silence_energy   <= afub_pkg::SILENCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afub_pkg::CFG_ENABLED:   cfg_r.enabled          <= cfg_data[0];
        afub_pkg::CFG_THRESHOLD: cfg_r.buffer_threshold <= cfg_data[afub_pkg::THR_W-1:0];
        afub_pkg::CFG_SILENCE:   cfg_r.silence_energy   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register; the left sample's square is formed on the way in and
  // stored with the frame, so a pull only has to add it
  logic              in_acc, fire, q_full;
  logic              s1_valid_r;
  afub_pkg::work_t   s1_r;
  logic [SB-1:0]     mag;
  logic [afub_pkg::SQ_W-1:0]  sq_in;

  assign in_stall = s1_valid_r && q_full;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = s1_valid_r && !q_full;

  // magnitude of the most negative sample is 2^(SB-1), which fits unsigned
  assign mag    = in_data.in_left[SB-1] ? SB'(-in_data.in_left) : SB'(in_data.in_left);
  assign sq_in  = afub_pkg::SQ_W'(mag) * afub_pkg::SQ_W'(mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.beat <= in_data;
      s1_r.sq   <= sq_in;
    end
  end

  // frame store: {left, right, left squared} per slot
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [afub_pkg::WORD_W-1:0] ram_wdata, ram_q;
  afub_pkg::out_beat_t         res;

  afub_ram #(
    .WIDTH (afub_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  afub_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_r),
    .cfg       (cfg_r),
    .ram_q     (ram_q),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  afub_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // input backs up only when the result queue is full
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall with empty result queue");

  // a beat is either a push or a pull, never both
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.from_store && out_data.push_accepted))
    else $error("result both pushed and pulled");

  // frames not taken from the store carry silence
  a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.from_store) |->
      (out_data.out_left == '0 && out_data.out_right == '0))
    else $error("nonzero samples on a frame not from the store");

  // a fire must land in the queue: one input beat in flight per result slot
  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !q_full)
    else $error("result written into a full queue");

endmodule

### tb/tb_audio_fifo_with_underrun_buffering.sv
`timescale 1ns / 100ps
// Self-checking testbench for audio_fifo_with_underrun_buffering: directed block cases, then
// random push/pull block traffic across several register settings. Depends on afub_pkg.
module tb_audio_fifo_with_underrun_buffering;
  import afub_pkg::*;

  localparam int STORE_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] ENERGY_CAP = 64'h03FF_FFFF_FFFF_FFFF;  // 2^58 - 1
  localparam logic [SE_W-1:0] SILENCE_MAX = '1;

  typedef enum int {
    SMP_RANDOM,
    SMP_QUIET,
    SMP_EXTREME
  } sample_kind_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLED;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  audio_fifo_with_underrun_buffering dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Ring buffer mirror. Starts in the post-reset state; reset is applied once.
  // ---------------------------------------------------------------------------
  logic [2*SAMPLE_BITS-1:0] ring [STORE_DEPTH];
  int unsigned ring_wr = 0;
  int unsigned ring_rd = 0;
  bit prebuf = 1'b1;
  bit push_ok = 1'b0;
  bit push_live = 1'b0;
  bit pull_live = 1'b0;
  bit pull_gated = 1'b0;
  int unsigned push_left = 0;
  int unsigned pull_left = 0;
  int unsigned pull_len = 0;
  logic [63:0] energy = '0;

  // register mirror
  bit reg_enabled = ENABLED_RST;
  logic [THR_W-1:0] reg_threshold = THRESHOLD_RST;
  logic [SE_W-1:0] reg_silence = SILENCE_RST;

  out_beat_t pending_results[$];

  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int frames_stored = 0;
  int frames_served = 0;
  int releases = 0;
  int rebuffers = 0;
  int phases_run = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int stall_left = 0;
  int cycle_count = 0;

  function automatic int unsigned ring_fill();
    return (ring_wr + STORE_DEPTH - ring_rd) % STORE_DEPTH;
  endfunction

  // Advance the mirror by one input beat and return the result beat it implies.
  function automatic out_beat_t next_frame_result(in_beat_t b);
    out_beat_t r;
    int unsigned room;
    int unsigned lvl;
    logic [2*SAMPLE_BITS-1:0] word;
    logic [63:0] mag;
    logic [63:0] sq;
    r = '0;
    if (b.command == CMD_PUSH) begin
      if (b.first_of_block) begin
        // space, enable and length are latched for the whole block
        room = (ring_rd + STORE_DEPTH - ring_wr - 1) % STORE_DEPTH;
        push_live = reg_enabled;
        push_ok = push_live && b.block_length != 0 && b.block_length <= room;
        push_left = push_ok ? b.block_length : 0;
      end
      if (push_ok && push_left > 0) begin
        ring[ring_wr] = {b.in_left, b.in_right};
        ring_wr = (ring_wr + 1) % STORE_DEPTH;
        push_left--;
        r.push_accepted = 1'b1;
        frames_stored++;
      end
      if (b.last_of_block) begin
        // threshold check runs even for a zero-length or dropped block
        if (push_live && prebuf && ring_fill() >= reg_threshold) begin
          prebuf = 1'b0;
          releases++;
        end
        push_live = 1'b0;
        push_ok = 1'b0;
        push_left = 0;
      end
    end else begin
      if (b.first_of_block) begin
        lvl = ring_fill();
        pull_live = reg_enabled;
        pull_gated = !pull_live || prebuf;
        pull_len = b.block_length;
        pull_left = pull_gated ? 0 : ((lvl < pull_len) ? lvl : pull_len);
        energy = '0;
      end
      if (pull_live && !pull_gated && pull_left > 0) begin
        word = ring[ring_rd];
        r.out_left = word[2*SAMPLE_BITS-1:SAMPLE_BITS];
        r.out_right = word[SAMPLE_BITS-1:0];
        r.from_store = 1'b1;
        ring_rd = (ring_rd + 1) % STORE_DEPTH;
        pull_left--;
        frames_served++;
        // left-channel energy, magnitude squared, saturating
        mag = 64'(word[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        if (word[2*SAMPLE_BITS-1])
          mag = (64'd1 << SAMPLE_BITS) - mag;
        sq = mag * mag;
        if (energy > ENERGY_CAP - sq)
          energy = ENERGY_CAP;
        else
          energy = energy + sq;
      end
      if (b.last_of_block) begin
        // quiet block that left less than a block behind: back to prebuffering
        if (pull_live && !pull_gated &&
            energy < 64'(reg_silence) * 64'(pull_len) &&
            ring_fill() < pull_len) begin
          if (!prebuf)
            rebuffers++;
          prebuf = 1'b1;
        end
        pull_live = 1'b0;
        pull_gated = 1'b0;
        pull_left = 0;
      end
    end
    r.buffering_now = prebuf;
    r.fill_level = FILL_W'(ring_fill());
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct)
      return 0;
    if ($urandom_range(9) == 0)
      return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(sample_kind_t kind, int k);
    case (kind)
      SMP_QUIET: begin
        return SAMPLE_BITS'($urandom_range(511)) - SAMPLE_BITS'(256);
      end
      SMP_EXTREME: begin
        case (k % 4)
          0: return 24'h800000;
          1: return 24'h7FFFFF;
          2: return 24'h000000;
          default: return 24'hFFFFFF;
        endcase
      end
      default: begin
        return SAMPLE_BITS'($urandom);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, then compare each accepted beat with the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : stall_gen
    int n;
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      n = pick_gap(rx_stall_pct);
      out_stall <= (n != 0);
      stall_left <= n;
    end
  end

  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %h",
                 $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_left", want.out_left, out_data.out_left);
        check_field("out_right", want.out_right, out_data.out_right);
        check_field("from_store", want.from_store, out_data.from_store);
        check_field("push_accepted", want.push_accepted, out_data.push_accepted);
        check_field("buffering_now", want.buffering_now, out_data.buffering_now);
        check_field("fill_level", want.fill_level, out_data.fill_level);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("audio_fifo_with_underrun_buffering regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Every task below starts and ends just after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_frame(input in_beat_t b);
    int gap;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(next_frame_result(b));
    beats_sent++;
    gap = pick_gap(tx_gap_pct);
    // with no gap valid stays high for the next beat
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_block(cmd_t c, logic [LEN_W-1:0] len, int frames,
                            sample_kind_t kind);
    in_beat_t b;
    for (int k = 0; k < frames; k++) begin
      b.command = c;
      b.first_of_block = (k == 0);
      b.last_of_block = (k == frames - 1);
      // length only matters on the first beat; the rest carry junk
      b.block_length = (k == 0) ? len : LEN_W'($urandom);
      b.in_left = pick_sample(kind, 2 * k);
      b.in_right = pick_sample(kind, 2 * k + 1);
      send_frame(b);
    end
  endtask

  // Drain all results, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_we high so back-to-back writes need no toggle; caller lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ENABLED: reg_enabled = val[0];
      CFG_THRESHOLD: reg_threshold = val[THR_W-1:0];
      CFG_SILENCE: reg_silence = val[SE_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: disabled, so nothing is stored and pulls give zeros.
  // Also beats that arrive before any block has started.
  task automatic test_idle_and_disabled();
    in_beat_t b;
    b = '0;
    b.command = CMD_PUSH;
    b.block_length = 13'd5;
    b.in_left = 24'h123456;
    b.in_right = 24'h654321;
    send_frame(b);
    b.command = CMD_PULL;
    send_frame(b);
    send_block(CMD_PUSH, 13'd2, 2, SMP_RANDOM);
    send_block(CMD_PULL, 13'd1, 1, SMP_RANDOM);
  endtask

  // Pulls stay gated until a push block ends at or above the threshold;
  // a zero-length push block still runs the threshold check.
  task automatic test_prebuffer_release();
    wait_idle();
    write_reg(CFG_ENABLED, CFG_DATA_W'(1));
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(4));
    write_reg(CFG_SILENCE, '0);
    cfg_we <= 1'b0;
    send_block(CMD_PUSH, 13'd3, 3, SMP_EXTREME);
    send_block(CMD_PULL, 13'd2, 2, SMP_RANDOM);
    wait_idle();
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(3));
    cfg_we <= 1'b0;
    send_block(CMD_PUSH, 13'd0, 1, SMP_RANDOM);
  endtask

  // Single-beat block, surplus push beats, pull running past the fill level.
  task automatic test_block_edges();
    send_block(CMD_PULL, 13'd1, 1, SMP_RANDOM);
    send_block(CMD_PUSH, 13'd2, 3, SMP_EXTREME);
    send_block(CMD_PULL, 13'd6, 5, SMP_RANDOM);
  endtask

  // Largest-length push block, a 4096-length block, zero-length pull,
  // then a quiet short pull that puts the block back into prebuffering.
  task automatic test_silence_rebuffer();
    wait_idle();
    write_reg(CFG_SILENCE, SILENCE_MAX);
    cfg_we <= 1'b0;
    send_block(CMD_PUSH, 13'h1FFF, 2, SMP_RANDOM);
    send_block(CMD_PUSH, 13'd4096, 1, SMP_EXTREME);
    send_block(CMD_PULL, 13'd0, 1, SMP_RANDOM);
    send_block(CMD_PULL, 13'd2, 2, SMP_RANDOM);
  endtask

  // Phases of random block traffic, each under its own register setting.
  // Phase boundaries drain fully, so the sender pauses for every result there.
  task automatic test_random_traffic();
    int phase;
    int taken;
    int in_phase;
    int roll;
    int len;
    int frames;
    cmd_t c;
    in_beat_t b;
    sample_kind_t kind;
    phase = 0;
    taken = 0;
    while (taken < 500) begin
      wait_idle();
      write_reg(CFG_ENABLED, CFG_DATA_W'((phase % 6 == 4) ? 0 : 1));
      case (phase % 5)
        0: write_reg(CFG_THRESHOLD, '0);
        1: write_reg(CFG_THRESHOLD, CFG_DATA_W'(16383));
        2: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(8, 1)));
        default: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(64)));
      endcase
      case (phase % 4)
        0: write_reg(CFG_SILENCE, SILENCE_MAX);
        1: write_reg(CFG_SILENCE, '0);
        2: write_reg(CFG_SILENCE, CFG_DATA_W'($urandom_range(100000)));
        default: write_reg(CFG_SILENCE, CFG_DATA_W'({$urandom, $urandom}));
      endcase
      cfg_we <= 1'b0;
      // every third phase runs back to back on both sides
      if (phase % 3 == 2) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct = $urandom_range(50, 10);
        rx_stall_pct = $urandom_range(50, 10);
      end
      in_phase = 0;
      while (in_phase < 60) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          // stray beat with no block start
          b.command = cmd_t'($urandom_range(1));
          b.first_of_block = 1'b0;
          b.last_of_block = 1'($urandom_range(1));
          b.block_length = LEN_W'($urandom);
          b.in_left = SAMPLE_BITS'($urandom);
          b.in_right = SAMPLE_BITS'($urandom);
          send_frame(b);
          in_phase++;
        end else begin
          c = ($urandom_range(99) < 55) ? CMD_PUSH : CMD_PULL;
          roll = $urandom_range(99);
          if (roll < 3)
            len = 0;
          else if (roll < 85)
            len = $urandom_range(12, 1);
          else if (roll < 95)
            len = $urandom_range(64, 13);
          else
            len = $urandom_range(8191);
          // long blocks are cut short by an early last beat
          frames = (len == 0) ? 1 : ((len > 16) ? $urandom_range(16, 1) : len);
          if ($urandom_range(9) == 0)
            frames = $urandom_range(frames + 3, 1);
          kind = ($urandom_range(2) == 0) ? SMP_QUIET : SMP_RANDOM;
          send_block(c, LEN_W'(len), frames, kind);
          in_phase += frames;
        end
      end
      taken += in_phase;
      phase++;
    end
    phases_run = phase;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    tx_gap_pct = 25;
    rx_stall_pct = 25;
    test_idle_and_disabled();
    test_prebuffer_release();
    test_block_edges();
    test_silence_rebuffer();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d beats over %0d random phases: %0d frames stored, %0d served",
             beats_sent, phases_run, frames_stored, frames_served);
    $display("%0d results checked, %0d prebuffer releases, %0d returns to prebuffering",
             results_seen, releases, rebuffers);
    if (errors == 0) begin
      $display("audio_fifo_with_underrun_buffering regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("audio_fifo_with_underrun_buffering regression: fail");
    end
    $finish;
  end

endmodule
